[rtl/ssc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the supersample circle compositor.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // sample store geometry
    localparam int STORE_AW    = 14;
    localparam int CH_W        = 16;
    localparam int POS_W       = 24;
    localparam int RAD_W       = 49;
    localparam int PIX_W       = 8;
    localparam int SAMPLES_DEF = 16;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 49;

    localparam logic [CH_W-1:0] FULL = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_RADIUS_SQ   = 3'd2,
        CFG_COLOR_RED   = 3'd3,
        CFG_COLOR_GREEN = 3'd4,
        CFG_COLOR_BLUE  = 3'd5,
        CFG_COLOR_ALPHA = 3'd6
    } cfg_reg_t;

    // request opcodes
    typedef enum logic [1:0] {
        OP_COMPOSITE = 2'd0,
        OP_FILL      = 2'd1,
        OP_RESOLVE   = 2'd2
    } op_t;

    // one stored sample
    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] a;
    } rgba_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_C_SQ,
        S_C_OV,
        S_C_SB,
        S_C_MUL,
        S_C_DIV,
        S_R_RD,
        S_R_LAST,
        S_R_PREP,
        S_R_DIV,
        S_R_OUT
    } state_t;

endpackage
`default_nettype wire

[rtl/ssc_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_store
// Sample color memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssc_store (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [ssc_pkg::STORE_AW-1:0] waddr,
    input  wire ssc_pkg::rgba_t               wdata,
    input  wire logic [ssc_pkg::STORE_AW-1:0] raddr,
    output ssc_pkg::rgba_t                    rdata
);
    import ssc_pkg::*;

    localparam int DEPTH = 1 << STORE_AW;

    rgba_t store_mem [DEPTH];
    rgba_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/ssc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_div
// Restoring divider lane, one quotient bit per cycle. The numerator's upper
// part (above QW bits) must be below the divisor.
// ----------------------------------------------------------------------------
module ssc_div #(
    parameter int NW = 46,
    parameter int DW = 37,
    parameter int QW = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo,
    output logic               done
);
    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    rem_reg;
    logic [QW-1:0]    low_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;

    // one restoring step
    always_comb
    begin
        trial    = {rem_reg, low_reg[QW-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(QW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(num[NW-1:QW]);
            low_reg <= num[QW-1:0];
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QW-2:0], ge};
        end
    end

    assign quo  = low_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[rtl/supersample_circle_compositor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// supersample_circle_compositor
// Fill writes straight from idle; composite runs 4 setup states, the 16-step
//   divider and a write back; resolve reads SAMPLES samples, then divides and
//   loads the output register. Requests: one at a time, set by the memory
//   read-modify-write and the bit-serial divider lanes.
// Reset: a clearing pass writes all 16384 samples to zero with in_stall high;
//   configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module supersample_circle_compositor #(
    parameter int SAMPLES = ssc_pkg::SAMPLES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   op,
    input  wire logic [ssc_pkg::STORE_AW-1:0] sample_index,
    input  wire logic signed [ssc_pkg::POS_W-1:0] sample_x,
    input  wire logic signed [ssc_pkg::POS_W-1:0] sample_y,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ssc_pkg::PIX_W-1:0]         pixel_red,
    output logic [ssc_pkg::PIX_W-1:0]         pixel_green,
    output logic [ssc_pkg::PIX_W-1:0]         pixel_blue,
    output logic [ssc_pkg::PIX_W-1:0]         pixel_alpha,
    // configuration channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ssc_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [ssc_pkg::CFG_DW-1:0]   cfg_data
);
    import ssc_pkg::*;

    localparam int SW = $clog2(SAMPLES + 1);
    localparam int KW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int AW = CH_W + SW;
    localparam int CW = 2 * CH_W + SW;
    localparam int NW = 42 + SW;
    localparam int DW = 33 + SW;
    localparam int QW = 16;
    localparam int LANES = 3;

    // mean opacity by reciprocal: alpha = floor((2*SA + 257*S) / (514*S))
    localparam int AK  = AW + SW + 12;
    localparam int AMW = AW + 5;
    localparam int APW = AW + 2 + AMW;
    localparam longint unsigned ADIV   = 64'(514 * SAMPLES);
    localparam longint unsigned ARECIP = ((64'd1 << AK) + ADIV - 64'd1) / ADIV;
    localparam logic [AW+1:0]  ABIAS = (AW+2)'(257 * SAMPLES);
    localparam logic [AMW-1:0] AMUL  = AMW'(ARECIP);

    // configuration registers
    logic signed [POS_W-1:0] center_x_reg, center_y_reg;
    logic [RAD_W-1:0]        radius_sq_reg;
    logic [CH_W-1:0]         color_red_reg, color_green_reg, color_blue_reg;
    logic [CH_W-1:0]         color_alpha_reg;

    // control
    state_t                state_reg, state_next;
    logic [STORE_AW-1:0]   clr_reg;
    logic [KW-1:0]         k_reg;
    logic                  rd_v_reg;
    logic                  out_valid_reg;

    // payload
    logic [STORE_AW-1:0]     idx_reg;
    logic signed [POS_W-1:0] x_reg, y_reg;
    logic [RAD_W-1:0]        sq_x_reg, sq_y_reg;
    logic [CH_W-1:0]         sa_reg, sb_reg, s_reg;
    logic [31:0]             prod_reg;
    rgba_t                   bcol_reg;
    logic [AW-1:0]           sum_a_reg;
    logic [CW-1:0]           sum_r_reg, sum_g_reg, sum_b_reg;
    logic [PIX_W-1:0]        pix_r_reg, pix_g_reg, pix_b_reg, pix_a_reg;

    // memory port
    logic                mem_we;
    logic [STORE_AW-1:0] mem_waddr, mem_raddr;
    rgba_t               mem_wdata, rd_data;

    // divider lanes
    logic              div_start;
    logic [NW-1:0]     dnum [LANES];
    logic [DW-1:0]     dden [LANES];
    logic [QW-1:0]     dquo [LANES];
    logic [LANES-1:0]  ddone;
    logic              div_done;

    logic accept;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign div_done  = &ddone;

    // rounded weighted sum for the over rule
    function automatic logic [NW-1:0] over_num(
        input logic [CH_W-1:0] a, input logic [CH_W-1:0] x,
        input logic [CH_W-1:0] b, input logic [CH_W-1:0] y,
        input logic [CH_W-1:0] s
    );
        logic [31:0] p1;
        logic [31:0] p2;
        p1 = a * x;
        p2 = b * y;
        return NW'(p1) + NW'(p2) + NW'(s >> 1);
    endfunction

    // saturate a quotient to 8 bits
    function automatic logic [PIX_W-1:0] sat8(input logic [QW-1:0] q);
        return (q > QW'(255)) ? 8'hFF : q[PIX_W-1:0];
    endfunction

    ssc_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_div
        ssc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (dnum[i]),
            .den   (dden[i]),
            .quo   (dquo[i]),
            .done  (ddone[i])
        );
    end

    // circle test terms
    logic signed [POS_W:0] dx, dy;
    logic [POS_W:0]        mx, my;
    logic [RAD_W:0]        d2;
    logic                  in_circle;
    always_comb
    begin
        dx        = $signed({x_reg[POS_W-1], x_reg})
                  - $signed({center_x_reg[POS_W-1], center_x_reg});
        dy        = $signed({y_reg[POS_W-1], y_reg})
                  - $signed({center_y_reg[POS_W-1], center_y_reg});
        mx        = dx[POS_W] ? (POS_W+1)'(0) - $unsigned(dx) : $unsigned(dx);
        my        = dy[POS_W] ? (POS_W+1)'(0) - $unsigned(dy) : $unsigned(dy);
        d2        = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        in_circle = d2 <= {1'b0, radius_sq_reg};
    end

    // back alpha: round((65535 - sa) * ba / 65535) by reciprocal and one fixup
    logic [CH_W-1:0] sa_comb, inv_sa;
    logic [31:0]     prod_comb;
    logic [32:0]     pe, prem;
    logic [16:0]     qe, s17;
    logic [CH_W-1:0] sb_comb, s_comb;
    always_comb
    begin
        sa_comb   = in_circle ? color_alpha_reg : '0;
        inv_sa    = FULL - sa_comb;
        prod_comb = inv_sa * rd_data.a;
        pe        = {1'b0, prod_reg} + 33'(prod_reg >> 16);
        qe        = pe[32:16];
        prem      = {1'b0, prod_reg} - {qe, 16'b0} + 33'(qe);
        sb_comb   = (prem >= 33'(FULL)) ? CH_W'(qe + 17'd1) : qe[CH_W-1:0];
        s17       = {1'b0, sa_reg} + {1'b0, sb_comb};
        s_comb    = s17[16] ? FULL : s17[CH_W-1:0];
    end

    // resolve accumulation terms
    logic [31:0] pc_r, pc_g, pc_b;
    always_comb
    begin
        pc_r = rd_data.r * rd_data.a;
        pc_g = rd_data.g * rd_data.a;
        pc_b = rd_data.b * rd_data.a;
    end

    // mean opacity: rounded SA / (257 * SAMPLES) by reciprocal multiplication
    logic [AW+1:0]  a_num;
    logic [APW-1:0] a_prod;
    always_comb
    begin
        a_num  = {1'b0, sum_a_reg, 1'b0} + ABIAS;
        a_prod = APW'(a_num) * APW'(AMUL);
    end

    // sequencer, memory port and divider loading
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = '0;
        mem_raddr  = idx_reg;
        div_start  = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            dnum[i] = '0;
            dden[i] = DW'(1);
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_COMPOSITE: state_next = S_C_SQ;
                        OP_FILL:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = sample_index;
                            mem_wdata = '{r: color_red_reg, g: color_green_reg,
                                          b: color_blue_reg, a: color_alpha_reg};
                        end
                        OP_RESOLVE:   state_next = S_R_RD;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_C_SQ:   state_next = S_C_OV;
            S_C_OV:   state_next = S_C_SB;
            S_C_SB:   state_next = S_C_MUL;
            S_C_MUL:
            begin
                div_start = 1'b1;
                dnum[0] = over_num(sa_reg, color_red_reg, sb_reg, bcol_reg.r, s_reg);
                dnum[1] = over_num(sa_reg, color_green_reg, sb_reg, bcol_reg.g, s_reg);
                dnum[2] = over_num(sa_reg, color_blue_reg, sb_reg, bcol_reg.b, s_reg);
                for (int i = 0; i < LANES; i++)
                begin
                    dden[i] = DW'(s_reg);
                end
                state_next = S_C_DIV;
            end
            S_C_DIV:
            begin
                if (div_done)
                begin
                    mem_we = 1'b1;
                    if (s_reg != '0)
                    begin
                        mem_wdata = '{r: dquo[0], g: dquo[1], b: dquo[2], a: s_reg};
                    end
                    state_next = S_IDLE;
                end
            end
            S_R_RD:
            begin
                mem_raddr = idx_reg + STORE_AW'(k_reg);
                if (k_reg == KW'(SAMPLES - 1))
                begin
                    state_next = S_R_LAST;
                end
            end
            S_R_LAST: state_next = S_R_PREP;
            S_R_PREP:
            begin
                div_start = 1'b1;
                dnum[0] = (NW'(sum_r_reg) << 9) - (NW'(sum_r_reg) << 1)
                        + (NW'(sum_a_reg) << 16) - NW'(sum_a_reg);
                dnum[1] = (NW'(sum_g_reg) << 9) - (NW'(sum_g_reg) << 1)
                        + (NW'(sum_a_reg) << 16) - NW'(sum_a_reg);
                dnum[2] = (NW'(sum_b_reg) << 9) - (NW'(sum_b_reg) << 1)
                        + (NW'(sum_a_reg) << 16) - NW'(sum_a_reg);
                for (int i = 0; i < LANES; i++)
                begin
                    dden[i] = (DW'(sum_a_reg) << 17) - (DW'(sum_a_reg) << 1);
                end
                state_next = S_R_DIV;
            end
            S_R_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_R_OUT;
                end
            end
            S_R_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == S_R_RD);
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + STORE_AW'(1);
            end
            if (state_reg == S_R_RD)
            begin
                k_reg <= k_reg + KW'(1);
            end
            else
            begin
                k_reg <= '0;
            end
            if (state_reg == S_R_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            radius_sq_reg   <= '0;
            color_red_reg   <= '0;
            color_green_reg <= '0;
            color_blue_reg  <= '0;
            color_alpha_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CENTER_X:    center_x_reg    <= cfg_data[POS_W-1:0];
                CFG_CENTER_Y:    center_y_reg    <= cfg_data[POS_W-1:0];
                CFG_RADIUS_SQ:   radius_sq_reg   <= cfg_data[RAD_W-1:0];
                CFG_COLOR_RED:   color_red_reg   <= cfg_data[CH_W-1:0];
                CFG_COLOR_GREEN: color_green_reg <= cfg_data[CH_W-1:0];
                CFG_COLOR_BLUE:  color_blue_reg  <= cfg_data[CH_W-1:0];
                CFG_COLOR_ALPHA: color_alpha_reg <= cfg_data[CH_W-1:0];
                default:         ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= sample_index;
            x_reg     <= sample_x;
            y_reg     <= sample_y;
            sum_a_reg <= '0;
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end
        if (state_reg == S_C_SQ)
        begin
            sq_x_reg <= RAD_W'(mx * mx);
            sq_y_reg <= RAD_W'(my * my);
        end
        if (state_reg == S_C_OV)
        begin
            sa_reg   <= sa_comb;
            prod_reg <= prod_comb + 32'd32767;
            bcol_reg <= rd_data;
        end
        if (state_reg == S_C_SB)
        begin
            sb_reg <= sb_comb;
            s_reg  <= s_comb;
        end
        if (rd_v_reg)
        begin
            sum_a_reg <= sum_a_reg + AW'(rd_data.a);
            sum_r_reg <= sum_r_reg + CW'(pc_r);
            sum_g_reg <= sum_g_reg + CW'(pc_g);
            sum_b_reg <= sum_b_reg + CW'(pc_b);
        end
        if (state_reg == S_R_OUT && (!out_valid_reg || !out_stall))
        begin
            pix_a_reg <= PIX_W'(a_prod >> AK);
            if (sum_a_reg == '0)
            begin
                pix_r_reg <= '0;
                pix_g_reg <= '0;
                pix_b_reg <= '0;
            end
            else
            begin
                pix_r_reg <= sat8(dquo[0]);
                pix_g_reg <= sat8(dquo[1]);
                pix_b_reg <= sat8(dquo[2]);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_red   = pix_r_reg;
    assign pixel_green = pix_g_reg;
    assign pixel_blue  = pix_b_reg;
    assign pixel_alpha = pix_a_reg;

`ifndef SYNTHESIS
    // accumulation only follows resolve reads
    a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> (state_reg == S_R_RD || state_reg == S_R_LAST))
        else $error("sample accumulation outside resolve");

    // divider finishes only while the sequencer waits for it
    a_div_window: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_C_DIV || state_reg == S_R_DIV))
        else $error("divider done outside a wait state");

    // a new result comes only from the resolve output step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_R_OUT)
        else $error("result raised outside resolve");

    // clearing pass writes zero every cycle
    a_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> (mem_we && mem_wdata == '0 && in_stall))
        else $error("clearing pass skipped a write");
`endif

endmodule
`default_nettype wire
